/* design/idr_pkg.sv */
// Package for the integer divide/remainder unit.
// Holds the operation codes and the per-stage control struct; no dependencies.

package idr_pkg;

    localparam logic [1:0] FUNC_DIVU = 2'd0;
    localparam logic [1:0] FUNC_REMU = 2'd1;
    localparam logic [1:0] FUNC_DIV  = 2'd2;
    localparam logic [1:0] FUNC_REM  = 2'd3;

    // Control bits that travel down the pipeline beside the datapath.
    typedef struct packed {
        logic [1:0] func;
        logic       dividend_neg;
        logic       divisor_neg;
        logic       divide_by_zero;
    } idr_ctl_t;

endpackage

/* design/idr_req_if.sv */
// Request channel of the divide/remainder unit: operation code and operands.
// Standalone interface; no package dependency.

interface idr_req_if #(
    parameter int WIDTH = 32
) ();
    logic             valid;
    logic             ready;
    logic [1:0]       func;
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;

    modport source (output valid, output func, output dividend, output divisor, input ready);
    modport sink   (input valid, input func, input dividend, input divisor, output ready);
endinterface

/* design/idr_rsp_if.sv */
// Response channel of the divide/remainder unit: one result per request.
// Standalone interface; no package dependency.

interface idr_rsp_if #(
    parameter int WIDTH = 32
) ();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

/* design/idr_prep.sv */
// Input stage: takes a request, forms operand magnitudes and control bits.
// Depends on idr_pkg and idr_req_if.

module idr_prep #(
    parameter int WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    idr_req_if.sink            req,
    output logic               out_valid,
    input  logic               out_ready,
    output idr_pkg::idr_ctl_t  out_ctl,
    output logic [WIDTH-1:0]   out_rem,
    output logic [WIDTH-1:0]   out_qd,
    output logic [WIDTH-1:0]   out_dvs
);

    logic              valid_reg;
    logic              load;
    logic              is_signed;
    logic              a_neg;
    logic              d_neg;
    logic [WIDTH-1:0]  a_mag;
    logic [WIDTH-1:0]  d_mag;
    idr_pkg::idr_ctl_t ctl_next;
    idr_pkg::idr_ctl_t ctl_reg;
    logic [WIDTH-1:0]  qd_reg;
    logic [WIDTH-1:0]  dvs_reg;

    assign req.ready = !valid_reg || out_ready;
    assign load      = req.valid && req.ready;

    assign is_signed = (req.func == idr_pkg::FUNC_DIV) || (req.func == idr_pkg::FUNC_REM);
    assign a_neg     = is_signed && req.dividend[WIDTH-1];
    assign d_neg     = is_signed && req.divisor[WIDTH-1];
    // The most negative value negates to itself, which the later stages rely on.
    assign a_mag     = a_neg ? (~req.dividend + {{(WIDTH-1){1'b0}}, 1'b1}) : req.dividend;
    assign d_mag     = d_neg ? (~req.divisor + {{(WIDTH-1){1'b0}}, 1'b1}) : req.divisor;

    always_comb
    begin
        ctl_next.func           = req.func;
        ctl_next.dividend_neg   = a_neg;
        ctl_next.divisor_neg    = d_neg;
        ctl_next.divide_by_zero = (req.divisor == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (req.ready)
            valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg <= ctl_next;
            qd_reg  <= a_mag;
            dvs_reg <= d_mag;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_rem   = '0;
    assign out_qd    = qd_reg;
    assign out_dvs   = dvs_reg;

endmodule

/* design/idr_cell.sv */
// One restoring-division step: shifts one dividend bit into the partial
// remainder and resolves one quotient bit. Depends on idr_pkg.

module idr_cell #(
    parameter int WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  idr_pkg::idr_ctl_t  in_ctl,
    input  logic [WIDTH-1:0]   in_rem,
    input  logic [WIDTH-1:0]   in_qd,
    input  logic [WIDTH-1:0]   in_dvs,
    output logic               out_valid,
    input  logic               out_ready,
    output idr_pkg::idr_ctl_t  out_ctl,
    output logic [WIDTH-1:0]   out_rem,
    output logic [WIDTH-1:0]   out_qd,
    output logic [WIDTH-1:0]   out_dvs
);

    logic              valid_reg;
    logic              load;
    logic [WIDTH:0]    trial;
    logic [WIDTH:0]    diff;
    logic              fits;
    idr_pkg::idr_ctl_t ctl_reg;
    logic [WIDTH-1:0]  rem_reg;
    logic [WIDTH-1:0]  rem_next;
    logic [WIDTH-1:0]  qd_reg;
    logic [WIDTH-1:0]  qd_next;
    logic [WIDTH-1:0]  dvs_reg;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // The partial remainder stays below the divisor, so the shifted value
    // needs one extra bit and the restored value fits back in WIDTH bits.
    assign trial    = {in_rem, in_qd[WIDTH-1]};
    assign diff     = trial - {1'b0, in_dvs};
    assign fits     = !diff[WIDTH];
    assign rem_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    assign qd_next  = {in_qd[WIDTH-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg <= in_ctl;
            rem_reg <= rem_next;
            qd_reg  <= qd_next;
            dvs_reg <= in_dvs;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_rem   = rem_reg;
    assign out_qd    = qd_reg;
    assign out_dvs   = dvs_reg;

endmodule

/* design/idr_post.sv */
// Output stage: selects quotient or remainder, applies sign and the
// divide-by-zero rule, and holds the result. Depends on idr_pkg and idr_rsp_if.

module idr_post #(
    parameter int WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  idr_pkg::idr_ctl_t  in_ctl,
    input  logic [WIDTH-1:0]   in_rem,
    input  logic [WIDTH-1:0]   in_qd,
    idr_rsp_if.source          rsp
);

    logic             valid_reg;
    logic             load;
    logic [WIDTH-1:0] quo;
    logic [WIDTH-1:0] quo_neg;
    logic [WIDTH-1:0] rem_neg;
    logic [WIDTH-1:0] result_next;
    logic [WIDTH-1:0] result_reg;

    assign in_ready = !valid_reg || rsp.ready;
    assign load     = in_valid && in_ready;

    // A zero divisor leaves a zero quotient and the dividend as remainder.
    assign quo     = in_ctl.divide_by_zero ? '0 : in_qd;
    assign quo_neg = ~quo + {{(WIDTH-1){1'b0}}, 1'b1};
    assign rem_neg = ~in_rem + {{(WIDTH-1){1'b0}}, 1'b1};

    always_comb
    begin
        case (in_ctl.func)
            idr_pkg::FUNC_DIVU: result_next = quo;
            idr_pkg::FUNC_REMU: result_next = in_rem;
            idr_pkg::FUNC_DIV:
                result_next = (in_ctl.dividend_neg != in_ctl.divisor_neg) ? quo_neg : quo;
            idr_pkg::FUNC_REM:
                result_next = in_ctl.dividend_neg ? rem_neg : in_rem;
            default: result_next = quo;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    assign rsp.valid  = valid_reg;
    assign rsp.result = result_reg;

endmodule

/* design/int32_divide_remainder_unit_top.sv */
// Top level of the integer divide/remainder unit: input stage, a row of
// WIDTH restoring-division cells, and the output stage.
// Depends on idr_pkg, idr_req_if, idr_rsp_if, idr_prep, idr_cell, idr_post.
//
//   channel  modport  payload                         transaction when
//   req      sink     func, dividend, divisor         req.valid && req.ready
//   rsp      source   result                          rsp.valid && rsp.ready
//
// Stages: one input register, one cell per quotient bit, one output register.
// A new transaction is taken in every cycle while results drain. Each stage
// holds its item when the one after it is full and stalled, and takes a new
// item into any empty stage, so bubbles close up. Reset clears only the stage
// valid flags.

module int32_divide_remainder_unit_top #(
    parameter int WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    idr_req_if.sink    req,
    idr_rsp_if.source  rsp
);

    logic              stage_valid [WIDTH+1];
    logic              stage_ready [WIDTH+1];
    idr_pkg::idr_ctl_t stage_ctl   [WIDTH+1];
    logic [WIDTH-1:0]  stage_rem   [WIDTH+1];
    logic [WIDTH-1:0]  stage_qd    [WIDTH+1];
    logic [WIDTH-1:0]  stage_dvs   [WIDTH+1];

    idr_prep #(
        .WIDTH (WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_ctl   (stage_ctl[0]),
        .out_rem   (stage_rem[0]),
        .out_qd    (stage_qd[0]),
        .out_dvs   (stage_dvs[0])
    );

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_cell
        idr_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_ctl    (stage_ctl[i]),
            .in_rem    (stage_rem[i]),
            .in_qd     (stage_qd[i]),
            .in_dvs    (stage_dvs[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_ctl   (stage_ctl[i+1]),
            .out_rem   (stage_rem[i+1]),
            .out_qd    (stage_qd[i+1]),
            .out_dvs   (stage_dvs[i+1])
        );
    end

    idr_post #(
        .WIDTH (WIDTH)
    ) u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stage_valid[WIDTH]),
        .in_ready (stage_ready[WIDTH]),
        .in_ctl   (stage_ctl[WIDTH]),
        .in_rem   (stage_rem[WIDTH]),
        .in_qd    (stage_qd[WIDTH]),
        .rsp      (rsp)
    );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for int32_divide_remainder_unit_top.
// Drives directed and random divisions through the request and response channels and
// checks every result against a behavioral predictor. Depends on idr_pkg, idr_req_if, idr_rsp_if.

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Holds the results still owed by the block, oldest first, and checks arrivals.
    class div_result_board;

        typedef struct {
            logic [1:0]  func;
            logic [31:0] dividend;
            logic [31:0] divisor;
            logic [31:0] result;
        } owed_result_t;

        owed_result_t pending_results[$];
        int           error_count;

        function new();
            error_count = 0;
        endfunction

        // Truncating division on magnitudes; divide by zero gives quotient 0 and
        // remainder equal to the dividend.
        function logic [31:0] predict_result(logic [1:0] func, logic [31:0] dividend,
                                             logic [31:0] divisor);
            logic        signed_op;
            logic        dividend_neg;
            logic        divisor_neg;
            logic [31:0] dividend_mag;
            logic [31:0] divisor_mag;
            logic [31:0] quotient;
            logic [31:0] remainder;
            signed_op    = (func == idr_pkg::FUNC_DIV) || (func == idr_pkg::FUNC_REM);
            dividend_neg = signed_op && dividend[31];
            divisor_neg  = signed_op && divisor[31];
            dividend_mag = dividend_neg ? (~dividend + 32'd1) : dividend;
            divisor_mag  = divisor_neg ? (~divisor + 32'd1) : divisor;
            if (divisor_mag == 32'd0)
            begin
                quotient  = 32'd0;
                remainder = dividend_mag;
            end
            else
            begin
                quotient  = dividend_mag / divisor_mag;
                remainder = dividend_mag % divisor_mag;
            end
            case (func)
                idr_pkg::FUNC_DIVU: return quotient;
                idr_pkg::FUNC_REMU: return remainder;
                idr_pkg::FUNC_DIV:
                    return (dividend_neg != divisor_neg) ? (~quotient + 32'd1) : quotient;
                default:   return dividend_neg ? (~remainder + 32'd1) : remainder;
            endcase
        endfunction

        function void note_request(logic [1:0] func, logic [31:0] dividend,
                                   logic [31:0] divisor);
            owed_result_t owed;
            owed.func     = func;
            owed.dividend = dividend;
            owed.divisor  = divisor;
            owed.result   = predict_result(func, dividend, divisor);
            pending_results.push_back(owed);
        endfunction

        function void check_result(logic [31:0] result);
            owed_result_t owed;
            if (pending_results.size() == 0)
            begin
                $error("result 0x%08h arrived with no request outstanding", result);
                error_count++;
            end
            else
            begin
                owed = pending_results.pop_front();
                if (result !== owed.result)
                begin
                    $error("result (func %0d, 0x%08h by 0x%08h): expected 0x%08h, actual 0x%08h",
                           owed.func, owed.dividend, owed.divisor, owed.result, result);
                    error_count++;
                end
            end
        endfunction

    endclass

    logic clk;
    logic rst_n;

    idr_req_if #(.WIDTH(32)) req_ch ();
    idr_rsp_if #(.WIDTH(32)) rsp_ch ();

    int32_divide_remainder_unit_top #(.WIDTH(32)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    div_result_board board = new();

    bit idle_on       = 1'b1;
    bit long_hold_req = 1'b0;
    int hold_left     = 0;
    int ready_draw;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Receiver: random back-pressure, plus one long hold-off on request.
    always
    begin
        @(negedge clk);
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left     = 150;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (!idle_on)
        begin
            rsp_ch.ready <= 1'b1;
        end
        else
        begin
            ready_draw = $urandom_range(0, 99);
            if (ready_draw < 75)
                rsp_ch.ready <= 1'b1;
            else
            begin
                hold_left = (ready_draw < 97) ? $urandom_range(0, 3) : $urandom_range(20, 60);
                rsp_ch.ready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.result);
    end

    function automatic int pick_gap();
        int draw;
        draw = $urandom_range(0, 99);
        if (!idle_on || draw < 60)
            return 0;
        else if (draw < 90)
            return $urandom_range(1, 3);
        else if (draw < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 50);
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] value;
        value = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return value;
            4, 5:       return $urandom_range(0, 255);
            6:
            begin
                case ($urandom_range(0, 5))
                    0:       return 32'h0000_0000;
                    1:       return 32'h0000_0001;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h8000_0000;
                    4:       return 32'h7FFF_FFFF;
                    default: return 32'hFFFF_FFFE;
                endcase
            end
            7:          return ~32'($urandom_range(0, 255)) + 32'd1;
            8:          return value >> $urandom_range(1, 31);
            default:    return 32'd1 << $urandom_range(0, 31);
        endcase
    endfunction

    task automatic send_request(input logic [1:0] func, input logic [31:0] dividend,
                                input logic [31:0] divisor);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid    <= 1'b1;
        req_ch.func     <= func;
        req_ch.dividend <= dividend;
        req_ch.divisor  <= divisor;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        board.note_request(func, dividend, divisor);
    endtask

    task automatic send_random_divisions(input int count);
        logic [1:0]  func;
        logic [31:0] dividend;
        logic [31:0] divisor;
        repeat (count)
        begin
            func     = 2'($urandom_range(0, 3));
            dividend = pick_operand();
            divisor  = pick_operand();
            // Keep some cases where the divisor is a little smaller than the dividend.
            if ($urandom_range(0, 7) == 0)
                divisor = dividend >> $urandom_range(0, 8);
            send_request(func, dividend, divisor);
        end
    endtask

    task automatic wait_for_all_results();
        while (board.pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] corner_dividends [6];
        logic [31:0] corner_divisors [6];
        logic [1:0]  func;

        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.func     <= idr_pkg::FUNC_DIVU;
        req_ch.dividend <= 32'd0;
        req_ch.divisor  <= 32'd0;
        rsp_ch.ready    <= 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Most negative by minus one, divide by zero, all ones by one, mixed signs,
        // and the largest positive value by the most negative one.
        corner_dividends = '{32'h8000_0000, 32'hDEAD_BEEF, 32'hFFFF_FFFF,
                             32'hFFFF_FFF9, 32'h0000_0007, 32'h7FFF_FFFF};
        corner_divisors  = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
                             32'h0000_0002, 32'hFFFF_FFFE, 32'h8000_0000};
        foreach (corner_dividends[i])
        begin
            for (int f = 0; f < 4; f++)
            begin
                func = 2'(f);
                send_request(func, corner_dividends[i], corner_divisors[i]);
            end
        end

        send_random_divisions(300);

        // Hold the receiver off while requests keep coming so the pipeline fills.
        idle_on       = 1'b0;
        long_hold_req = 1'b1;
        send_random_divisions(60);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait_for_all_results();

        send_random_divisions(200);
        idle_on = 1'b1;
        send_random_divisions(340);
        @(negedge clk);
        req_ch.valid <= 1'b0;

        wait_for_all_results();
        repeat (40) @(posedge clk);
        if (board.error_count == 0 && board.pending_results.size() == 0)
            $display("** int32_divide_remainder_unit_top: PASSED **");
        else
            $display("** int32_divide_remainder_unit_top: FAILED **");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("** int32_divide_remainder_unit_top: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
design/idr_pkg.sv
design/idr_req_if.sv
design/idr_rsp_if.sv
design/idr_prep.sv
design/idr_cell.sv
design/idr_post.sv
design/int32_divide_remainder_unit_top.sv
tb/testbench.sv
